// ===== design/hdg_pkg.sv =====
// Shared types, widths and arctangent constants for the compass heading pipeline.
package hdg_pkg;

   // Port field widths
   localparam int FIELD_W   = 17;
   localparam int DECL_W    = 15;
   localparam int HEADING_W = 15;

   // Register port
   localparam int        CSR_AW     = 3;
   localparam int        CSR_DW     = 32;
   localparam logic      DECL_INDEX = 1'b0;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 28;
   localparam int IN_SHIFT     = 14;
   localparam int XW           = 34;
   localparam int ZW           = 32;
   localparam int Z_FRAC       = 24;

   // 90 degrees in 2^-24 degree units
   localparam logic signed [ZW-1:0] Z_MAX = 32'sd1509949440;

   // atan(2^-i) in 2^-24 degree units, rounded to nearest
   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
      32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
      32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
      32'sd234683,    32'sd117342,    32'sd58671,     32'sd29335,
      32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
      32'sd917,       32'sd458,       32'sd229,       32'sd115,
      32'sd57,        32'sd29,        32'sd14,        32'sd7
   };

   // Quadrant and special-case flags carried beside the CORDIC data
   typedef struct packed {
      logic x_neg;
      logic y_pos;
      logic y_neg;
      logic x_zero;
      logic both_zero;
   } quad_type;

   // One CORDIC pipeline stage
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      quad_type             quad;
   } cordic_stage_type;

endpackage

// ===== design/compass_heading_from_field.sv =====
// Compass heading from X/Y field: pipelined CORDIC arctangent plus declination.
// Pipeline: a request accepted at a clock edge passes through 1 input stage, 28 CORDIC
//   stages, then the round, quadrant and declination stages before its result appears.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset clears the stage valid bits and the declination register to zero.
module compass_heading_from_field
   import hdg_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic signed [FIELD_W-1:0]  req_field_x,
   input  logic signed [FIELD_W-1:0]  req_field_y,
   // result channel
   output logic                       rsp_valid,
   output logic [HEADING_W-1:0]       rsp_heading,
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int AW        = ANGLE_FRAC_BITS + 7;
   localparam int DW        = ANGLE_FRAC_BITS + 18;
   localparam int RND_SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [DW-1:0] B90  = DW'(90)  << ANGLE_FRAC_BITS;
   localparam logic signed [DW-1:0] B270 = DW'(270) << ANGLE_FRAC_BITS;
   localparam logic signed [DW-1:0] FULL = DW'(360) << ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] RND_HALF = ZW'(1) << (RND_SHIFT - 1);

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   logic signed [DECL_W-1:0] decl_ff;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {{(CSR_DW-DECL_W){decl_ff[DECL_W-1]}}, decl_ff};

   // Load declination on a completed write to any address whose bit 2 equals DECL_INDEX
   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == DECL_INDEX)) begin
         decl_ff <= csr_pwdata[DECL_W-1:0];
      end
   end

   // The pipeline never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Input stage: magnitudes, quadrant flags
   // ---------------------------------------------------------------
   logic                        stage_valid_ff [CORDIC_STEPS+1];
   cordic_stage_type            stage_ff       [CORDIC_STEPS+1];
   cordic_stage_type            stage0_in;
   logic signed [FIELD_W:0]     ext_x;
   logic signed [FIELD_W:0]     ext_y;
   logic [FIELD_W:0]            abs_x;
   logic [FIELD_W:0]            abs_y;

   always_comb begin
      ext_x = {req_field_x[FIELD_W-1], req_field_x};
      ext_y = {req_field_y[FIELD_W-1], req_field_y};
      abs_x = ext_x[FIELD_W] ? (FIELD_W+1)'(-ext_x) : ext_x;
      abs_y = ext_y[FIELD_W] ? (FIELD_W+1)'(-ext_y) : ext_y;
      stage0_in.x              = XW'(abs_x) <<< IN_SHIFT;
      stage0_in.y              = XW'(abs_y) <<< IN_SHIFT;
      stage0_in.z              = '0;
      stage0_in.quad.x_neg     = req_field_x[FIELD_W-1];
      stage0_in.quad.y_neg     = req_field_y[FIELD_W-1];
      stage0_in.quad.y_pos     = !req_field_y[FIELD_W-1] && (req_field_y != '0);
      stage0_in.quad.x_zero    = (req_field_x == '0);
      stage0_in.quad.both_zero = (req_field_x == '0) && (req_field_y == '0);
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff[0] <= 1'b0;
      end else begin
         stage_valid_ff[0] <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= stage0_in;
   end

   // ---------------------------------------------------------------
   // CORDIC vectoring stages, one micro-rotation per stage
   // ---------------------------------------------------------------
   for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
      cordic_stage_type     step_in;
      logic signed [XW-1:0] cur_x;
      logic signed [XW-1:0] cur_y;
      logic signed [XW-1:0] shf_x;
      logic signed [XW-1:0] shf_y;

      // Rotate towards the x axis
      always_comb begin
         cur_x        = stage_ff[gi].x;
         cur_y        = stage_ff[gi].y;
         shf_x        = cur_x >>> gi;
         shf_y        = cur_y >>> gi;
         step_in.quad = stage_ff[gi].quad;
         if (cur_y > 0) begin
            step_in.x = cur_x + shf_y;
            step_in.y = cur_y - shf_x;
            step_in.z = stage_ff[gi].z + ATAN_TAB[gi];
         end else begin
            step_in.x = cur_x - shf_y;
            step_in.y = cur_y + shf_x;
            step_in.z = stage_ff[gi].z - ATAN_TAB[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff[gi+1] <= 1'b0;
         end else begin
            stage_valid_ff[gi+1] <= stage_valid_ff[gi];
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[gi+1] <= step_in;
      end
   end

   // ---------------------------------------------------------------
   // Clamp and round the angle to output units
   // ---------------------------------------------------------------
   logic                     rnd_valid_ff;
   logic [AW-1:0]            angle_ff;
   logic [AW-1:0]            angle_in;
   quad_type                 rnd_quad_ff;
   logic signed [ZW-1:0]     z_final;
   logic signed [ZW-1:0]     z_clamp;
   logic signed [ZW-1:0]     z_round;

   always_comb begin
      z_final = stage_ff[CORDIC_STEPS].z;
      if (stage_ff[CORDIC_STEPS].quad.x_zero) begin
         z_clamp = Z_MAX;
      end else if (z_final < 0) begin
         z_clamp = '0;
      end else if (z_final > Z_MAX) begin
         z_clamp = Z_MAX;
      end else begin
         z_clamp = z_final;
      end
      z_round = z_clamp + RND_HALF;
      if (stage_ff[CORDIC_STEPS].quad.both_zero) begin
         angle_in = '0;
      end else begin
         angle_in = z_round[RND_SHIFT +: AW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else begin
         rnd_valid_ff <= stage_valid_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      rnd_quad_ff <= stage_ff[CORDIC_STEPS].quad;
   end

   // ---------------------------------------------------------------
   // Quadrant formula
   // ---------------------------------------------------------------
   logic                  quad_valid_ff;
   logic signed [DW-1:0]  quad_deg_ff;
   logic signed [DW-1:0]  quad_deg_in;
   logic signed [DW-1:0]  angle_ext;

   always_comb begin
      angle_ext = DW'(angle_ff);
      if (rnd_quad_ff.x_neg) begin
         quad_deg_in = rnd_quad_ff.y_pos ? (B90 - angle_ext) : (B90 + angle_ext);
      end else begin
         quad_deg_in = rnd_quad_ff.y_neg ? (B270 - angle_ext) : (B270 + angle_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
      end else begin
         quad_valid_ff <= rnd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      quad_deg_ff <= quad_deg_in;
   end

   // ---------------------------------------------------------------
   // Add declination, wrap once, drive the result
   // ---------------------------------------------------------------
   logic                  out_valid_ff;
   logic [HEADING_W-1:0]  heading_ff;
   logic [HEADING_W-1:0]  heading_in;
   logic signed [DW-1:0]  decl_sum;
   logic signed [DW-1:0]  wrapped;

   always_comb begin
      decl_sum = quad_deg_ff + DW'(decl_ff);
      if (decl_ff > 0) begin
         wrapped = (decl_sum > FULL) ? (decl_sum - FULL) : decl_sum;
      end else begin
         wrapped = (decl_sum < 0) ? (decl_sum + FULL) : decl_sum;
      end
      heading_in = wrapped[HEADING_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= quad_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_heading = heading_ff;

endmodule

// ===== design/hdg_checker.sv =====
// Port-level checks for the compass heading pipeline, bound to the top level.
module hdg_checker
   import hdg_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 6
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [HEADING_W-1:0]      rsp_heading
);

   // input stage, CORDIC stages, then round, quadrant and declination stages
   localparam int LATENCY = CORDIC_STEPS + 4;
   localparam logic [HEADING_W-1:0] FULL_UNITS = HEADING_W'(360 << ANGLE_FRAC_BITS);
   localparam logic RANGE_CHECK = (ANGLE_FRAC_BITS == 6);

   // Drop all results in flight on reset
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe high straight after reset");

   // Every accepted request yields a result after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted request produced no result");

   // No result without a request accepted the fixed latency before
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching request");

   // Heading stays within one full turn at the default resolution
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!RANGE_CHECK || (rsp_heading <= FULL_UNITS)))
      else $error("heading beyond 360 degrees");

endmodule

bind compass_heading_from_field hdg_checker #(
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_hdg_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_heading (rsp_heading)
);
